FILE: src/pun_pkg.sv
// Shared constants for the plane unit normal block.
package pun_pkg;
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS = 14;
  localparam int OUT_W = 16;
  localparam int NUM_POINTS_FIELDS = 9;
endpackage

FILE: src/plane_unit_normal_top.sv
// Top level of the plane unit normal block.
// Takes three points per transfer and returns the unit normal of their plane in signed
// fixed point with FRAC_BITS fraction bits, truncated toward zero; collinear points give
// a zero vector with the degenerate flag set. One transfer is accepted every cycle while
// the output side is not stalled; the data passes through the front stages, the square root
// stages (one root bit per stage), the divider stages (one quotient bit per stage) and the
// output register. A stall on the output side holds the whole pipeline.
module plane_unit_normal_top #(
  parameter int COORD_BITS = pun_pkg::COORD_BITS,
  parameter int FRAC_BITS = pun_pkg::FRAC_BITS,
  localparam int IN_W = ((pun_pkg::NUM_POINTS_FIELDS * COORD_BITS + 7) / 8) * 8,
  localparam int MAG_W = 2 * (COORD_BITS + 1),
  localparam int SQ_W = 2 * MAG_W + 2,
  localparam int Q_W = FRAC_BITS + 1,
  localparam int OUT_W = pun_pkg::OUT_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z,
  // point_c_x, point_c_y, point_c_z, zero fill
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // normal_x, normal_y, normal_z
  output logic [3*OUT_W-1:0] m_tdata,
  // degenerate
  output logic              m_tuser
);
  logic               ce;
  logic               f_valid;
  logic [3*MAG_W-1:0] f_mags;
  logic [2:0]         f_signs;
  logic [SQ_W-1:0]    f_sum;
  logic               r_valid;
  logic [MAG_W-1:0]   r_root;
  logic [3*MAG_W-1:0] r_mags;
  logic [2:0]         r_signs;
  logic               d_valid;
  logic [3*Q_W-1:0]   d_quots;
  logic [2:0]         d_signs;
  logic               d_degen;
  logic [3*OUT_W-1:0] result;

  assign ce = m_tready || !m_tvalid;
  assign s_tready = ce;

  pun_front #(.CB(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(s_tvalid),
    .points(s_tdata[pun_pkg::NUM_POINTS_FIELDS*COORD_BITS-1:0]),
    .out_valid(f_valid), .mags(f_mags), .signs(f_signs), .sum(f_sum)
  );

  pun_sqrt #(.MAG_W(MAG_W)) u_sqrt (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(f_valid), .sum(f_sum), .in_mags(f_mags), .in_signs(f_signs),
    .out_valid(r_valid), .root_out(r_root), .out_mags(r_mags), .out_signs(r_signs)
  );

  pun_div #(.MAG_W(MAG_W), .FRAC(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .ce(ce),
    .in_valid(r_valid), .root(r_root), .in_mags(r_mags), .in_signs(r_signs),
    .out_valid(d_valid), .quots(d_quots), .out_signs(d_signs), .out_degen(d_degen)
  );

  // Apply the sign and keep the low output bits; a wide fraction wraps.
  for (genvar j = 0; j < 3; j++) begin : g_comp
    logic signed [Q_W:0] sv;
    assign sv = d_signs[j] ? -signed'({1'b0, d_quots[j*Q_W +: Q_W]})
                           : signed'({1'b0, d_quots[j*Q_W +: Q_W]});
    assign result[j*OUT_W +: OUT_W] = d_degen ? '0 : OUT_W'(sv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= result;
      m_tuser <= d_degen;
    end
  end
endmodule

FILE: src/pun_front.sv
// Edge vectors, cross product, component magnitudes and the sum of their squares.
module pun_front #(
  parameter int CB = pun_pkg::COORD_BITS,
  localparam int DB = CB + 1,
  localparam int PB = 2 * DB,
  localparam int NB = PB + 1,
  localparam int MAG_W = PB,
  localparam int SQ_W = 2 * MAG_W + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  logic                 in_valid,
  input  logic [9*CB-1:0]      points,
  output logic                 out_valid,
  output logic [3*MAG_W-1:0]   mags,
  output logic [2:0]           signs,
  output logic [SQ_W-1:0]      sum
);
  logic signed [CB-1:0] c [0:8];
  logic signed [DB-1:0] u [0:2];
  logic signed [DB-1:0] v [0:2];
  logic signed [PB-1:0] p [0:5];
  logic signed [NB-1:0] n [0:2];
  logic [MAG_W-1:0] m [0:2];
  logic [2:0] sg4;
  logic [2:0] sg5;
  logic [MAG_W-1:0] m5 [0:2];
  logic [2*MAG_W-1:0] sq [0:2];
  logic [6:1] vld;

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      c[j] = signed'(points[j*CB +: CB]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j < 3; j++) begin
        u[j] <= DB'(c[j]) - DB'(c[j+3]);
        v[j] <= DB'(c[j]) - DB'(c[j+6]);
      end
      p[0] <= PB'(u[1]) * PB'(v[2]);
      p[1] <= PB'(u[2]) * PB'(v[1]);
      p[2] <= PB'(u[2]) * PB'(v[0]);
      p[3] <= PB'(u[0]) * PB'(v[2]);
      p[4] <= PB'(u[0]) * PB'(v[1]);
      p[5] <= PB'(u[1]) * PB'(v[0]);
      for (int j = 0; j < 3; j++) begin
        n[j] <= NB'(p[2*j]) - NB'(p[2*j+1]);
        m[j] <= n[j][NB-1] ? MAG_W'(-n[j]) : MAG_W'(n[j]);
        sg4[j] <= n[j][NB-1];
        m5[j] <= m[j];
        sq[j] <= (2*MAG_W)'(m[j]) * (2*MAG_W)'(m[j]);
        mags[j*MAG_W +: MAG_W] <= m5[j];
      end
      sg5 <= sg4;
      signs <= sg5;
      sum <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
    end
  end

  assign out_valid = vld[6];
endmodule

FILE: src/pun_sqrt.sv
// Pipelined floor square root, one root bit per stage.
module pun_sqrt #(
  parameter int MAG_W = 26,
  localparam int R_W = MAG_W,
  localparam int SQ_W = 2 * MAG_W + 2,
  localparam int TW = SQ_W + 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  logic [SQ_W-1:0]    sum,
  input  logic [3*MAG_W-1:0] in_mags,
  input  logic [2:0]         in_signs,
  output logic               out_valid,
  output logic [R_W-1:0]     root_out,
  output logic [3*MAG_W-1:0] out_mags,
  output logic [2:0]         out_signs
);
  logic               vld  [0:R_W];
  logic [SQ_W-1:0]    s    [0:R_W];
  logic [R_W-1:0]     root [0:R_W];
  logic [SQ_W-1:0]    sq   [0:R_W];
  logic [3*MAG_W-1:0] mg   [0:R_W];
  logic [2:0]         sg   [0:R_W];

  assign vld[0] = in_valid;
  assign s[0] = sum;
  assign root[0] = '0;
  assign sq[0] = '0;
  assign mg[0] = in_mags;
  assign sg[0] = in_signs;

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    localparam int I = R_W - 1 - k;
    logic [TW-1:0] trial;
    // (root + 2^I)^2 = root^2 + root * 2^(I+1) + 2^(2I)
    assign trial = TW'(sq[k]) + (TW'(root[k]) << (I + 1)) + (TW'(1) << (2 * I));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        s[k+1] <= s[k];
        mg[k+1] <= mg[k];
        sg[k+1] <= sg[k];
        if (trial <= TW'(s[k])) begin
          root[k+1] <= root[k] | (R_W'(1) << I);
          sq[k+1] <= trial[SQ_W-1:0];
        end else begin
          root[k+1] <= root[k];
          sq[k+1] <= sq[k];
        end
      end
    end
  end

  assign out_valid = vld[R_W];
  assign root_out = root[R_W];
  assign out_mags = mg[R_W];
  assign out_signs = sg[R_W];
endmodule

FILE: src/pun_div.sv
// Pipelined restoring divider for the three components, one quotient bit per stage.
module pun_div #(
  parameter int MAG_W = 26,
  parameter int FRAC = pun_pkg::FRAC_BITS,
  localparam int R_W = MAG_W,
  localparam int Q_W = FRAC + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  logic [R_W-1:0]     root,
  input  logic [3*MAG_W-1:0] in_mags,
  input  logic [2:0]         in_signs,
  output logic               out_valid,
  output logic [3*Q_W-1:0]   quots,
  output logic [2:0]         out_signs,
  output logic               out_degen
);
  logic           vld [0:Q_W];
  logic [R_W-1:0] d   [0:Q_W];
  logic [2:0]     sg  [0:Q_W];
  logic           dg  [0:Q_W];
  logic [R_W-1:0] rem [0:Q_W][0:2];
  logic [Q_W-1:0] q   [0:Q_W][0:2];
  logic [2:0]     lsb;

  assign vld[0] = in_valid;
  assign d[0] = root;
  assign sg[0] = in_signs;
  assign dg[0] = (root == '0);

  // The dividend is mag * 2^FRAC; the top part mag >> 1 is already below the root.
  for (genvar j = 0; j < 3; j++) begin : g_init
    assign rem[0][j] = R_W'(in_mags[j*MAG_W +: MAG_W] >> 1);
    assign lsb[j] = in_mags[j*MAG_W];
    assign q[0][j] = '0;
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (ce) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        d[k+1] <= d[k];
        sg[k+1] <= sg[k];
        dg[k+1] <= dg[k];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [R_W:0] shifted;
      logic         take;
      assign shifted = {rem[k][j], (k == 0) ? lsb[j] : 1'b0};
      assign take = (shifted >= {1'b0, d[k]});

      always_ff @(posedge clk) begin
        if (ce) begin
          rem[k+1][j] <= take ? R_W'(shifted - {1'b0, d[k]}) : shifted[R_W-1:0];
          q[k+1][j] <= {q[k][j][Q_W-2:0], take};
        end
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_out
    assign quots[j*Q_W +: Q_W] = q[Q_W][j];
  end

  assign out_valid = vld[Q_W];
  assign out_signs = sg[Q_W];
  assign out_degen = dg[Q_W];
endmodule

FILE: verif/plane_unit_normal_top_tb.sv
// Self-checking testbench for the plane unit normal block.
`timescale 1ns / 100ps

module plane_unit_normal_top_tb;
  localparam int IN_W = ((pun_pkg::NUM_POINTS_FIELDS * pun_pkg::COORD_BITS + 7) / 8) * 8;
  localparam int LATENCY = 6 + 2 * (pun_pkg::COORD_BITS + 1) + (pun_pkg::FRAC_BITS + 1) + 1;

  typedef logic signed [pun_pkg::COORD_BITS-1:0] coord_t;
  typedef struct packed {
    logic signed [pun_pkg::OUT_W-1:0] nx;
    logic signed [pun_pkg::OUT_W-1:0] ny;
    logic signed [pun_pkg::OUT_W-1:0] nz;
    logic degenerate;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [3*pun_pkg::OUT_W-1:0] m_tdata;
  logic m_tuser;

  logic [IN_W-1:0] point_sets[$];
  normal_t normals_due[$];
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  plane_unit_normal_top DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Floor square root of an exact sum of squares.
  function automatic longint unsigned floor_sqrt(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [pun_pkg::OUT_W-1:0] scaled(longint n, longint unsigned r);
    longint unsigned q;
    q = ((n < 0 ? -n : n) << pun_pkg::FRAC_BITS) / r;
    if (n < 0) q = -q;
    return q[pun_pkg::OUT_W-1:0];
  endfunction

  function automatic normal_t plane_normal(logic [IN_W-1:0] d);
    longint p[9];
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
    longint unsigned r;
    normal_t o;
    for (int i = 0; i < 9; i++)
      p[i] = coord_t'(d[i*pun_pkg::COORD_BITS +: pun_pkg::COORD_BITS]);
    ux = p[0] - p[3]; uy = p[1] - p[4]; uz = p[2] - p[5];
    vx = p[0] - p[6]; vy = p[1] - p[7]; vz = p[2] - p[8];
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    r = floor_sqrt(nx * nx + ny * ny + nz * nz);
    if (r == 0) begin
      o = '{0, 0, 0, 1'b1};
    end else begin
      o = '{scaled(nx, r), scaled(ny, r), scaled(nz, r), 1'b0};
    end
    return o;
  endfunction

  function automatic logic [IN_W-1:0] pack9(longint p[9]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++)
      d[i*pun_pkg::COORD_BITS +: pun_pkg::COORD_BITS] = p[i][pun_pkg::COORD_BITS-1:0];
    return d;
  endfunction

  function automatic longint rnd_coord(int mode);
    case (mode)
      0: return longint'($urandom_range(0, 4095)) - 2048;
      1: return $urandom_range(0, 1) ? 2047 : -2048;
      default: return longint'($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  initial begin
    longint p[9];
    longint t;
    int mode;
    p = '{2047, 2047, 2047, -2048, -2048, -2048, 2047, -2048, 2047};
    point_sets.push_back(pack9(p));
    p = '{-2048, -2048, -2048, 2047, 2047, 2047, -2048, 2047, -2048};
    point_sets.push_back(pack9(p));
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    point_sets.push_back(pack9(p));
    p = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
    point_sets.push_back(pack9(p));
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    point_sets.push_back(pack9(p));
    p = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
    point_sets.push_back(pack9(p));
    p = '{2047, -2048, 0, -2048, 2047, 0, -2048, -2048, 2047};
    point_sets.push_back(pack9(p));
    p = '{-2048, 2047, -2048, 2047, -2048, 2047, 2047, 2047, -2048};
    point_sets.push_back(pack9(p));
    p = '{5, 5, 5, 5, 5, 5, 7, 1, -3};
    point_sets.push_back(pack9(p));
    p = '{0, 0, 0, 1, 1, 1, 2, 1, 1};
    point_sets.push_back(pack9(p));
    for (int k = 0; k < 450; k++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++)
        p[i] = rnd_coord(mode < 6 ? 0 : (mode < 8 ? 1 : 2));
      // Every tenth or so set is made collinear: C = A + 2(B - A) where it fits.
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 3; i++) begin
          p[3+i] = p[i] + rnd_coord(2) * (i + 1);
          t = 2 * p[3+i] - p[i];
          p[6+i] = t;
        end
        for (int i = 0; i < 9; i++)
          if (p[i] > 2047 || p[i] < -2048) p[i] = 0;
      end
      point_sets.push_back(pack9(p));
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (point_sets.size() == 0 && !s_tvalid);
    wait (normals_due.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("plane_unit_normal_top_tb OK");
    end else begin
      $display("plane_unit_normal_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("plane_unit_normal_top_tb NOT OK");
    $finish;
  end

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) normals_due.push_back(plane_normal(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (point_sets.size() > 0) begin
          s_tdata <= point_sets.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: repeating stall pattern, always ready in part of it and randomly stalled in the rest.
  always @(posedge clk) begin
    normal_t got;
    normal_t want;
    stall_phase <= (stall_phase + 1) % 64;
    m_tready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 2) != 0);
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[0 +: pun_pkg::OUT_W], m_tdata[pun_pkg::OUT_W +: pun_pkg::OUT_W],
              m_tdata[2*pun_pkg::OUT_W +: pun_pkg::OUT_W], m_tuser};
      if (normals_due.size() == 0) begin
        $error("result transfer with no expected normal");
        errors++;
      end else begin
        want = normals_due.pop_front();
        if (got.nx !== want.nx) begin
          $error("normal_x expected %0d actual %0d", want.nx, got.nx); errors++;
        end
        if (got.ny !== want.ny) begin
          $error("normal_y expected %0d actual %0d", want.ny, got.ny); errors++;
        end
        if (got.nz !== want.nz) begin
          $error("normal_z expected %0d actual %0d", want.nz, got.nz); errors++;
        end
        if (got.degenerate !== want.degenerate) begin
          $error("degenerate expected %0d actual %0d", want.degenerate, got.degenerate);
          errors++;
        end
      end
    end
  end
endmodule
